[design/swsr_pkg.sv]
package swsr_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] REG_START_LOW     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_RELEASE       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_RESPONSE_WAIT = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_RESPONSE_CHK  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BIT_SAMPLE    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_BYTES_FRAME   = 3'd5;

  localparam logic [14:0] START_LOW_RST     = 15'd18000;
  localparam logic [7:0]  RELEASE_RST       = 8'd20;
  localparam logic [7:0]  RESPONSE_WAIT_RST = 8'd40;
  localparam logic [7:0]  RESPONSE_CHK_RST  = 8'd80;
  localparam logic [7:0]  BIT_SAMPLE_RST    = 8'd40;
  localparam logic [2:0]  BYTES_FRAME_RST   = 3'd5;

  localparam logic [1:0] RESP_NO_LOW  = 2'd0;
  localparam logic [1:0] RESP_PRESENT = 2'd1;
  localparam logic [1:0] RESP_NO_HIGH = 2'd2;

  typedef struct packed {
    logic [14:0] start_low_us;
    logic [7:0]  release_us;
    logic [7:0]  response_wait_us;
    logic [7:0]  response_check_us;
    logic [7:0]  bit_sample_us;
    logic [2:0]  bytes_per_frame;
  } cfg_t;

  typedef struct packed {
    logic       drive_low;
    logic       drive_high;
    logic       response_ready;
    logic [1:0] response_code;
    logic       byte_ready;
    logic [7:0] data_byte;
    logic       last_byte;
    logic       busy_res;
  } res_t;

endpackage

[design/swsr_cfg.sv]
module swsr_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              wr_en,
  input  logic [swsr_pkg::CfgIdxW-1:0]      wr_index,
  input  logic [swsr_pkg::CfgDataW-1:0]     wr_data,
  output swsr_pkg::cfg_t                    cfg
);

  swsr_pkg::cfg_t cfg_r;
  swsr_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        swsr_pkg::REG_START_LOW:     cfg_nxt.start_low_us      = wr_data[14:0];
        swsr_pkg::REG_RELEASE:       cfg_nxt.release_us        = wr_data[7:0];
        swsr_pkg::REG_RESPONSE_WAIT: cfg_nxt.response_wait_us  = wr_data[7:0];
        swsr_pkg::REG_RESPONSE_CHK:  cfg_nxt.response_check_us = wr_data[7:0];
        swsr_pkg::REG_BIT_SAMPLE:    cfg_nxt.bit_sample_us     = wr_data[7:0];
        swsr_pkg::REG_BYTES_FRAME:   cfg_nxt.bytes_per_frame   = wr_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_low_us      <= swsr_pkg::START_LOW_RST;
      cfg_r.release_us        <= swsr_pkg::RELEASE_RST;
      cfg_r.response_wait_us  <= swsr_pkg::RESPONSE_WAIT_RST;
      cfg_r.response_check_us <= swsr_pkg::RESPONSE_CHK_RST;
      cfg_r.bit_sample_us     <= swsr_pkg::BIT_SAMPLE_RST;
      cfg_r.bytes_per_frame   <= swsr_pkg::BYTES_FRAME_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[design/swsr_core.sv]
module swsr_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic            action,
  input  logic            level,
  input  swsr_pkg::cfg_t  cfg,
  output swsr_pkg::res_t  res
);

  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_LOW  = 4'd1;
  localparam logic [3:0] PH_DRIVE_HIGH = 4'd2;
  localparam logic [3:0] PH_WAIT1      = 4'd3;
  localparam logic [3:0] PH_WAIT2      = 4'd4;
  localparam logic [3:0] PH_FALL_FAIL  = 4'd5;
  localparam logic [3:0] PH_FALL_GOOD  = 4'd6;
  localparam logic [3:0] PH_BIT_RISE   = 4'd7;
  localparam logic [3:0] PH_BIT_DELAY  = 4'd8;
  localparam logic [3:0] PH_BIT_FALL   = 4'd9;

  logic [3:0]  phase_r, phase_nxt;
  logic [14:0] usec_cnt_r, usec_cnt_nxt;
  logic [2:0]  bit_cnt_r, bit_cnt_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [2:0]  byte_cnt_r, byte_cnt_nxt;

  logic [14:0] cnt_inc;
  assign cnt_inc = usec_cnt_r + 15'd1;

  always_comb begin
    logic       finish;
    logic [7:0] fin_byte;
    logic [3:0] byte_cnt_inc;

    phase_nxt    = phase_r;
    usec_cnt_nxt = usec_cnt_r;
    bit_cnt_nxt  = bit_cnt_r;
    shift_nxt    = shift_r;
    byte_cnt_nxt = byte_cnt_r;
    res          = '0;
    finish       = 1'b0;
    fin_byte     = shift_r;
    byte_cnt_inc = {1'b0, byte_cnt_r} + 4'd1;

    if (action) begin
      phase_nxt    = PH_START_LOW;
      usec_cnt_nxt = '0;
      bit_cnt_nxt  = '0;
      shift_nxt    = '0;
      byte_cnt_nxt = '0;
    end else begin
      case (phase_r)
        PH_IDLE: ;
        PH_START_LOW: begin
          usec_cnt_nxt = cnt_inc;
          if (cnt_inc >= cfg.start_low_us) begin
            phase_nxt    = PH_DRIVE_HIGH;
            usec_cnt_nxt = '0;
          end
        end
        PH_DRIVE_HIGH: begin
          usec_cnt_nxt = cnt_inc;
          if (cnt_inc >= {7'd0, cfg.release_us}) begin
            phase_nxt    = PH_WAIT1;
            usec_cnt_nxt = '0;
          end
        end
        PH_WAIT1: begin
          usec_cnt_nxt = cnt_inc;
          if (cnt_inc >= {7'd0, cfg.response_wait_us}) begin
            usec_cnt_nxt = '0;
            if (!level) begin
              phase_nxt = PH_WAIT2;
            end else begin
              res.response_ready = 1'b1;
              res.response_code  = swsr_pkg::RESP_NO_LOW;
              phase_nxt          = PH_FALL_FAIL;
            end
          end
        end
        PH_WAIT2: begin
          usec_cnt_nxt = cnt_inc;
          if (cnt_inc >= {7'd0, cfg.response_check_us}) begin
            usec_cnt_nxt       = '0;
            res.response_ready = 1'b1;
            if (level) begin
              res.response_code = swsr_pkg::RESP_PRESENT;
              phase_nxt         = PH_FALL_GOOD;
            end else begin
              res.response_code = swsr_pkg::RESP_NO_HIGH;
              phase_nxt         = PH_IDLE;
            end
          end
        end
        PH_FALL_FAIL: begin
          if (!level) phase_nxt = PH_IDLE;
        end
        PH_FALL_GOOD: begin
          if (!level) phase_nxt = PH_BIT_RISE;
        end
        PH_BIT_RISE: begin
          if (level) begin
            phase_nxt    = PH_BIT_DELAY;
            usec_cnt_nxt = '0;
          end
        end
        PH_BIT_DELAY: begin
          usec_cnt_nxt = cnt_inc;
          if (cnt_inc >= {7'd0, cfg.bit_sample_us}) begin
            usec_cnt_nxt = '0;
            fin_byte     = {shift_r[6:0], level};
            shift_nxt    = fin_byte;
            if (level) phase_nxt = PH_BIT_FALL;
            else       finish    = 1'b1;
          end
        end
        PH_BIT_FALL: begin
          if (!level) finish = 1'b1;
        end
        default: phase_nxt = PH_IDLE;
      endcase

      // bit close-out: a byte goes out after its eighth bit
      if (finish) begin
        if (bit_cnt_r == 3'd7) begin
          res.byte_ready = 1'b1;
          res.data_byte  = fin_byte;
          shift_nxt      = '0;
          bit_cnt_nxt    = '0;
          if (byte_cnt_inc >= {1'b0, cfg.bytes_per_frame}) begin
            res.last_byte = 1'b1;
            byte_cnt_nxt  = '0;
            phase_nxt     = PH_IDLE;
          end else begin
            byte_cnt_nxt = byte_cnt_inc[2:0];
            phase_nxt    = PH_BIT_RISE;
          end
        end else begin
          bit_cnt_nxt = bit_cnt_r + 3'd1;
          phase_nxt   = PH_BIT_RISE;
        end
      end
    end

    res.drive_low  = (phase_nxt == PH_START_LOW);
    res.drive_high = (phase_nxt == PH_DRIVE_HIGH);
    res.busy_res   = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      usec_cnt_r <= '0;
      bit_cnt_r  <= '0;
      shift_r    <= '0;
      byte_cnt_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      usec_cnt_r <= usec_cnt_nxt;
      bit_cnt_r  <= bit_cnt_nxt;
      shift_r    <= shift_nxt;
      byte_cnt_r <= byte_cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  // counter only runs in timed phases
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (usec_cnt_r == 15'd0))
    else $error("timer running while idle");

  // a bit being assembled only exists while reading data
  a_bits_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (bit_cnt_r == 3'd0))
    else $error("bit count left over in idle");

  // state only moves on an accepted step
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(phase_r))
    else $error("phase changed without a step");
`endif

endmodule

[design/single_wire_sensor_reader.sv]
// An accepted request is held in the input register, then goes through the step
//   logic into the result register before it shows on out_*.
// Throughput: one request per cycle while out_stall is low; one result per request.
// Reset (rst_n low, synchronous): both pipeline stages empty, sequencer idle
//   with counters cleared, configuration registers back to their defaults.
module single_wire_sensor_reader (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_action,
  input  logic                          in_line_level,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_drive_low,
  output logic                          out_drive_high,
  output logic                          out_response_ready,
  output logic [1:0]                    out_response_code,
  output logic                          out_byte_ready,
  output logic [7:0]                    out_data_byte,
  output logic                          out_last_byte,
  output logic                          out_busy_res,

  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swsr_pkg::CfgDataW-1:0] cfg_data
);

  swsr_pkg::cfg_t cfg;
  swsr_pkg::res_t res;
  swsr_pkg::res_t res_r;

  logic in_valid_r, in_valid_nxt;
  logic action_r, level_r;
  logic out_valid_r, out_valid_nxt;
  logic out_free, advance, in_load;

  assign cfg_ready = 1'b1;

  swsr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_load  = in_valid && !in_stall;

  assign in_valid_nxt  = in_load ? 1'b1 : (advance ? 1'b0 : in_valid_r);
  assign out_valid_nxt = out_free ? advance : out_valid_r;

  swsr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .action (action_r),
    .level  (level_r),
    .cfg    (cfg),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      action_r <= in_action;
      level_r  <= in_line_level;
    end
    if (advance) begin
      res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_drive_low      = res_r.drive_low;
  assign out_drive_high     = res_r.drive_high;
  assign out_response_ready = res_r.response_ready;
  assign out_response_code  = res_r.response_code;
  assign out_byte_ready     = res_r.byte_ready;
  assign out_data_byte      = res_r.data_byte;
  assign out_last_byte      = res_r.last_byte;
  assign out_busy_res       = res_r.busy_res;

`ifndef SYNTHESIS
  a_drive_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_drive_low && out_drive_high))
    else $error("line driven low and high together");

  // the last byte of a frame ends the transaction
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_byte) |-> (out_byte_ready && !out_busy_res))
    else $error("last byte without frame end");

  a_byte_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_byte_ready) |-> (out_data_byte == 8'd0 && !out_last_byte))
    else $error("byte fields set without a byte");

  // only the missing-high response ends the transaction at once
  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_response_ready && out_response_code != swsr_pkg::RESP_NO_HIGH)
      |-> out_busy_res)
    else $error("response concluded but block went idle");

  // a stalled input request moves on as soon as the result slot frees
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !out_valid_r) |=> out_valid_r)
    else $error("held request not advanced into empty result slot");
`endif

endmodule

[tb/swsr_sequence_checker.sv]
`timescale 1ns / 1ps

module swsr_sequence_checker (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          in_action,
  input  logic                          in_line_level,

  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic                          out_drive_low,
  input  logic                          out_drive_high,
  input  logic                          out_response_ready,
  input  logic [1:0]                    out_response_code,
  input  logic                          out_byte_ready,
  input  logic [7:0]                    out_data_byte,
  input  logic                          out_last_byte,
  input  logic                          out_busy_res,

  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [swsr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [swsr_pkg::CfgDataW-1:0] cfg_data,

  output int unsigned                   fail_count,
  output int unsigned                   pending
);

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_START_LOW,
    SEQ_DRIVE_HIGH,
    SEQ_WAIT_LOW,
    SEQ_WAIT_HIGH,
    SEQ_FALL_FAIL,
    SEQ_FALL_GOOD,
    SEQ_BIT_RISE,
    SEQ_BIT_DELAY,
    SEQ_BIT_FALL
  } seq_phase_t;

  seq_phase_t       phase;
  logic [14:0]      us_count;
  logic [2:0]       bit_idx;
  logic [7:0]       shift_reg;
  logic [2:0]       byte_idx;
  swsr_pkg::cfg_t   cfg;
  swsr_pkg::res_t   expected_res_q [$];

  // A zero delay still takes one microsecond: the count is bumped first.
  function automatic bit tick_elapsed(input logic [14:0] delay);
    us_count = us_count + 15'd1;
    return us_count >= delay;
  endfunction

  function automatic void close_bit(inout swsr_pkg::res_t r);
    if (bit_idx == 3'd7) begin
      r.byte_ready = 1'b1;
      r.data_byte  = shift_reg;
      shift_reg    = '0;
      bit_idx      = '0;
      if ({1'b0, byte_idx} + 4'd1 >= {1'b0, cfg.bytes_per_frame}) begin
        r.last_byte = 1'b1;
        byte_idx    = '0;
        phase       = SEQ_IDLE;
      end else begin
        byte_idx = byte_idx + 3'd1;
        phase    = SEQ_BIT_RISE;
      end
    end else begin
      bit_idx = bit_idx + 3'd1;
      phase   = SEQ_BIT_RISE;
    end
  endfunction

  function automatic swsr_pkg::res_t host_step(input logic start, input logic lvl);
    swsr_pkg::res_t r;
    r = '0;
    if (start) begin
      phase     = SEQ_START_LOW;
      us_count  = '0;
      bit_idx   = '0;
      shift_reg = '0;
      byte_idx  = '0;
    end else begin
      case (phase)
        SEQ_START_LOW: if (tick_elapsed(cfg.start_low_us)) begin
          phase    = SEQ_DRIVE_HIGH;
          us_count = '0;
        end
        SEQ_DRIVE_HIGH: if (tick_elapsed(15'(cfg.release_us))) begin
          phase    = SEQ_WAIT_LOW;
          us_count = '0;
        end
        SEQ_WAIT_LOW: if (tick_elapsed(15'(cfg.response_wait_us))) begin
          us_count = '0;
          if (!lvl) begin
            phase = SEQ_WAIT_HIGH;
          end else begin
            r.response_ready = 1'b1;
            r.response_code  = swsr_pkg::RESP_NO_LOW;
            phase            = SEQ_FALL_FAIL;
          end
        end
        SEQ_WAIT_HIGH: if (tick_elapsed(15'(cfg.response_check_us))) begin
          us_count         = '0;
          r.response_ready = 1'b1;
          if (lvl) begin
            r.response_code = swsr_pkg::RESP_PRESENT;
            phase           = SEQ_FALL_GOOD;
          end else begin
            r.response_code = swsr_pkg::RESP_NO_HIGH;
            phase           = SEQ_IDLE;
          end
        end
        SEQ_FALL_FAIL: if (!lvl) phase = SEQ_IDLE;
        SEQ_FALL_GOOD: if (!lvl) phase = SEQ_BIT_RISE;
        SEQ_BIT_RISE: if (lvl) begin
          phase    = SEQ_BIT_DELAY;
          us_count = '0;
        end
        SEQ_BIT_DELAY: if (tick_elapsed(15'(cfg.bit_sample_us))) begin
          us_count  = '0;
          shift_reg = {shift_reg[6:0], lvl};
          // a low sample already is the fall
          if (lvl) phase = SEQ_BIT_FALL;
          else close_bit(r);
        end
        SEQ_BIT_FALL: if (!lvl) close_bit(r);
        default: phase = SEQ_IDLE;
      endcase
    end
    r.drive_low  = (phase == SEQ_START_LOW);
    r.drive_high = (phase == SEQ_DRIVE_HIGH);
    r.busy_res   = (phase != SEQ_IDLE);
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin : track
    swsr_pkg::res_t want;
    swsr_pkg::res_t got;
    if (!rst_n) begin
      phase      = SEQ_IDLE;
      us_count   = '0;
      bit_idx    = '0;
      shift_reg  = '0;
      byte_idx   = '0;
      cfg        = '{start_low_us: swsr_pkg::START_LOW_RST,
                     release_us: swsr_pkg::RELEASE_RST,
                     response_wait_us: swsr_pkg::RESPONSE_WAIT_RST,
                     response_check_us: swsr_pkg::RESPONSE_CHK_RST,
                     bit_sample_us: swsr_pkg::BIT_SAMPLE_RST,
                     bytes_per_frame: swsr_pkg::BYTES_FRAME_RST};
      fail_count = 0;
      expected_res_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          swsr_pkg::REG_START_LOW:     cfg.start_low_us      = cfg_data;
          swsr_pkg::REG_RELEASE:       cfg.release_us        = cfg_data[7:0];
          swsr_pkg::REG_RESPONSE_WAIT: cfg.response_wait_us  = cfg_data[7:0];
          swsr_pkg::REG_RESPONSE_CHK:  cfg.response_check_us = cfg_data[7:0];
          swsr_pkg::REG_BIT_SAMPLE:    cfg.bit_sample_us     = cfg_data[7:0];
          swsr_pkg::REG_BYTES_FRAME:   cfg.bytes_per_frame   = cfg_data[2:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        expected_res_q.push_back(host_step(in_action, in_line_level));
      end
      if (out_valid && !out_stall) begin
        got = {out_drive_low, out_drive_high, out_response_ready, out_response_code,
               out_byte_ready, out_data_byte, out_last_byte, out_busy_res};
        if (expected_res_q.size() == 0) begin
          $error("result with no request outstanding: %h", got);
          fail_count++;
        end else begin
          want = expected_res_q.pop_front();
          check_field("drive_low", 8'(want.drive_low), 8'(got.drive_low));
          check_field("drive_high", 8'(want.drive_high), 8'(got.drive_high));
          check_field("response_ready", 8'(want.response_ready), 8'(got.response_ready));
          check_field("response_code", 8'(want.response_code), 8'(got.response_code));
          check_field("byte_ready", 8'(want.byte_ready), 8'(got.byte_ready));
          check_field("data_byte", want.data_byte, got.data_byte);
          check_field("last_byte", 8'(want.last_byte), 8'(got.last_byte));
          check_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
        end
      end
    end
    pending <= expected_res_q.size();
  end

endmodule

[tb/single_wire_sensor_reader_tb.sv]
`timescale 1ns / 1ps

module single_wire_sensor_reader_tb;

  localparam logic ACT_TICK  = 1'b0;
  localparam logic ACT_START = 1'b1;
  // unmapped register indexes, written to check they are ignored
  localparam logic [swsr_pkg::CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [swsr_pkg::CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned PHASE_REQS    = 200;
  localparam int unsigned MAX_CFG_TICKS = 120;

  typedef enum logic [1:0] {FR_GOOD, FR_NO_LOW, FR_NO_HIGH, FR_NOISY} frame_kind_t;

  logic                          clk           = 1'b0;
  logic                          rst_n         = 1'b0;
  logic                          in_valid      = 1'b0;
  logic                          in_stall;
  logic                          in_action     = 1'b0;
  logic                          in_line_level = 1'b0;
  logic                          out_valid;
  logic                          out_stall     = 1'b0;
  logic                          out_drive_low;
  logic                          out_drive_high;
  logic                          out_response_ready;
  logic [1:0]                    out_response_code;
  logic                          out_byte_ready;
  logic [7:0]                    out_data_byte;
  logic                          out_last_byte;
  logic                          out_busy_res;
  logic                          cfg_valid     = 1'b0;
  logic                          cfg_ready;
  logic [swsr_pkg::CfgIdxW-1:0]  cfg_index     = '0;
  logic [swsr_pkg::CfgDataW-1:0] cfg_data      = '0;

  int unsigned    fail_count;
  int unsigned    pending;
  int unsigned    quiet_cycles = 0;
  int unsigned    sent_reqs    = 0;
  int unsigned    idle_pct     = 0;
  int unsigned    stall_pct    = 0;
  bit             pause_pending = 1'b0;
  swsr_pkg::cfg_t cur_cfg;
  bit             level_plan [$];

  always #5 clk = ~clk;

  single_wire_sensor_reader i_dut (.*);

  swsr_sequence_checker i_checker (.*);

  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic int unsigned at_least_one(input int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void plan_fall();
    repeat ($urandom_range(0, 3)) level_plan.push_back(1'b1);
    level_plan.push_back(1'b0);
  endfunction

  // Line levels for the ticks after a start, timed to the current setting.
  // Levels the block does not look at are random.
  function automatic void plan_frame(input frame_kind_t kind);
    int unsigned nbytes;
    logic [7:0]  data;
    level_plan.delete();
    repeat (at_least_one(cur_cfg.start_low_us) + at_least_one(cur_cfg.release_us) +
            at_least_one(cur_cfg.response_wait_us) - 1)
      level_plan.push_back(1'($urandom_range(0, 1)));
    level_plan.push_back(kind == FR_NO_LOW);
    if (kind == FR_NO_LOW) begin
      plan_fall();
      return;
    end
    repeat (at_least_one(cur_cfg.response_check_us) - 1)
      level_plan.push_back(1'($urandom_range(0, 1)));
    level_plan.push_back(kind != FR_NO_HIGH);
    if (kind == FR_NO_HIGH) return;
    plan_fall();
    nbytes = at_least_one(cur_cfg.bytes_per_frame);
    for (int b = 0; b < nbytes; b++) begin
      data = 8'($urandom_range(0, 255));
      for (int i = 7; i >= 0; i--) begin
        repeat ($urandom_range(0, 3)) level_plan.push_back(1'b0);
        level_plan.push_back(1'b1);
        repeat (at_least_one(cur_cfg.bit_sample_us) - 1)
          level_plan.push_back(1'($urandom_range(0, 1)));
        level_plan.push_back(data[i]);
        if (data[i]) plan_fall();
      end
    end
  endfunction

  task automatic send_req(input logic act, input logic lvl);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_action     <= act;
    in_line_level <= lvl;
    do @(posedge clk); while (in_stall);
  endtask

  // pending is registered, hence the first clock before looking at it
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input swsr_pkg::cfg_t c, input bit spares);
    logic [swsr_pkg::CfgIdxW-1:0]  idx;
    logic [swsr_pkg::CfgDataW-1:0] val;
    cur_cfg = c;
    for (int i = 0; i < (spares ? 8 : 6); i++) begin
      idx = swsr_pkg::CfgIdxW'(i);
      case (idx)
        swsr_pkg::REG_START_LOW:     val = c.start_low_us;
        swsr_pkg::REG_RELEASE:       val = swsr_pkg::CfgDataW'(c.release_us);
        swsr_pkg::REG_RESPONSE_WAIT: val = swsr_pkg::CfgDataW'(c.response_wait_us);
        swsr_pkg::REG_RESPONSE_CHK:  val = swsr_pkg::CfgDataW'(c.response_check_us);
        swsr_pkg::REG_BIT_SAMPLE:    val = swsr_pkg::CfgDataW'(c.bit_sample_us);
        swsr_pkg::REG_BYTES_FRAME:   val = swsr_pkg::CfgDataW'(c.bytes_per_frame);
        REG_SPARE_LO, REG_SPARE_HI:  val = swsr_pkg::CfgDataW'($urandom_range(0, 32767));
        default:                     val = '0;
      endcase
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= val;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic swsr_pkg::cfg_t small_cfg();
    swsr_pkg::cfg_t c;
    c.start_low_us      = 15'($urandom_range(0, 8));
    c.release_us        = 8'($urandom_range(0, 4));
    c.response_wait_us  = 8'($urandom_range(0, 4));
    c.response_check_us = 8'($urandom_range(0, 4));
    c.bit_sample_us     = 8'($urandom_range(0, 6));
    c.bytes_per_frame   = 3'($urandom_range(0, 7));
    return c;
  endfunction

  // An abort cuts the frame short; the next start restarts the block.
  task automatic run_frame(input frame_kind_t kind, input bit abort);
    int unsigned n;
    logic        lvl;
    plan_frame(kind);
    n = abort ? $urandom_range(1, level_plan.size()) : level_plan.size();
    send_req(ACT_START, 1'($urandom_range(0, 1)));
    for (int i = 0; i < n; i++) begin
      lvl = level_plan[i];
      if (kind == FR_NOISY && $urandom_range(0, 9) == 0) lvl = ~lvl;
      if (pause_pending && i == n / 2) begin
        drain();
        pause_pending = 1'b0;
      end
      send_req(ACT_TICK, lvl);
    end
    sent_reqs += n + 1;
  endtask

  initial begin
    int unsigned roll;
    int unsigned goal;
    frame_kind_t kind;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // zero delays and zero bytes_per_frame all act as one
    write_cfg('0, 1'b1);
    send_req(ACT_TICK, 1'b0);
    send_req(ACT_TICK, 1'b1);
    send_req(ACT_START, 1'b1);
    send_req(ACT_TICK, 1'b0);
    send_req(ACT_START, 1'b0);
    run_frame(FR_NO_LOW, 1'b0);
    run_frame(FR_NO_HIGH, 1'b0);

    for (int p = 0; p < 6; p++) begin
      drain();
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 50; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 50; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      if (p == 3) begin
        // every register at its maximum: the start pulse outlasts these ticks,
        // the next phase's start request restarts the block
        write_cfg('1, 1'b0);
        send_req(ACT_START, 1'b0);
        repeat (MAX_CFG_TICKS) send_req(ACT_TICK, 1'($urandom_range(0, 1)));
        sent_reqs += MAX_CFG_TICKS + 1;
      end else begin
        write_cfg(small_cfg(), p == 1);
        if (p == 2) pause_pending = 1'b1;
        goal = sent_reqs + PHASE_REQS;
        while (sent_reqs < goal) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            // raw line noise with the odd start request
            repeat (12) send_req(($urandom_range(0, 15) == 0) ? ACT_START : ACT_TICK,
                                 1'($urandom_range(0, 1)));
            sent_reqs += 12;
          end else begin
            kind = (roll < 68) ? FR_GOOD : (roll < 78) ? FR_NO_LOW :
                   (roll < 88) ? FR_NO_HIGH : FR_NOISY;
            run_frame(kind, $urandom_range(0, 7) == 0);
          end
          repeat ($urandom_range(0, 2)) send_req(ACT_TICK, 1'($urandom_range(0, 1)));
        end
        // leaves the block idle before the next register writes
        run_frame(FR_NO_HIGH, 1'b0);
      end
    end

    drain();
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
